### sv/shi_pkg.sv
// Shared item types and status codes of the symbol hash insert engine.
package shi_pkg;

  localparam int CHAR_W   = 8;
  localparam int ADDR_W   = 20;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 7;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] name_char;
    logic              name_final;
    logic [ADDR_W-1:0] symbol_address;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] insert_status;
    logic [INDEX_W-1:0]  slot_index;
  } out_item_t;

endpackage

### sv/symbol_hash_insert_core.sv
// Symbol table insert engine: open addressing with linear probing.
//
// Input channel (in_valid/in_stall/in_data): one name character per item; the
// item with name_final set is the last character and carries the address.
// Result channel (out_valid/out_stall/out_data): one result per final item,
// with insert status and slot index. Non-final items give no result.
// After reset the engine runs a clearing pass over the slot table, one slot
// per cycle, with in_stall high. A non-final character is taken while the
// engine stays idle. A final character starts the hash on the shared
// multiplier (reciprocal quotient and remainder of the sum by HASH_MODULUS,
// scale by SEGMENT_STRIDE, quotient and remainder by TABLE_SLOTS). Each probed
// slot reads its slot record, and when lengths agree the characters are then
// compared one at a time; an insert writes the name characters to the
// character memory. S_RESULT loads the result register once it is free. A
// name longer than NAME_CHARS goes straight to S_RESULT with STATUS_TOO_LONG.
// in_stall is high whenever the engine is not idle. A stalled result holds in
// the output register while further non-final characters are still taken.
module symbol_hash_insert_core #(
  parameter int TABLE_SLOTS    = 100,
  parameter int HASH_MODULUS   = 10,
  parameter int SEGMENT_STRIDE = 10,
  parameter int NAME_CHARS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  shi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output shi_pkg::out_item_t out_data
);
  import shi_pkg::*;

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int PC_W    = $clog2(TABLE_SLOTS + 1);
  localparam int LEN_W   = $clog2(NAME_CHARS + 2);
  localparam int CIDX_W  = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
  localparam int SUM_W   = $clog2(NAME_CHARS * 255 + 1);
  localparam int HM_W    = $clog2(HASH_MODULUS + 1);
  localparam int PROD_W  = HM_W + $clog2(SEGMENT_STRIDE + 1);
  localparam int DVD_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int CHAR_DEPTH = TABLE_SLOTS * (1 << CIDX_W);
  // Reciprocals rounded up; exact quotients for dividends of SUM_W / PROD_W bits
  localparam int HM_K    = SUM_W + $clog2(HASH_MODULUS);
  localparam int HM_RCP  = ((1 << HM_K) + HASH_MODULUS - 1) / HASH_MODULUS;
  localparam int TS_K    = PROD_W + $clog2(TABLE_SLOTS);
  localparam int TS_RCP  = ((1 << TS_K) + TABLE_SLOTS - 1) / TABLE_SLOTS;
  localparam int OPB_W   = (DVD_W + 2 > SLOT_W + 1) ? DVD_W + 2 : SLOT_W + 1;
  localparam int MUL_W   = DVD_W + OPB_W;

  typedef struct packed {
    logic              used;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
  } meta_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HREM, S_SCALE, S_MODT, S_MREM, S_PROBE_RD,
    S_PROBE_CHK, S_CMP_RD, S_CMP_CHK, S_WRITE, S_RESULT
  } state_t;

  state_t state_r;

  // Pending name
  logic [CHAR_W-1:0] pend_chars_r [NAME_CHARS];
  logic [LEN_W-1:0]  pend_len_r;
  logic [SUM_W-1:0]  sum_r;
  logic [ADDR_W-1:0] addr_r;

  // Shared multiplier
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVD_W-1:0] mul_a;
  logic [OPB_W-1:0] mul_b;
  logic [MUL_W-1:0] mul_p;

  // Probe
  logic [SLOT_W-1:0]   slot_r;
  logic [PC_W-1:0]     probe_cnt_r;
  logic [LEN_W-1:0]    cidx_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  // Memories
  meta_t             meta_mem [TABLE_SLOTS];
  logic [CHAR_W-1:0] char_mem [CHAR_DEPTH];
  meta_t             meta_q_r;
  logic [CHAR_W-1:0] char_q_r;
  logic              meta_we;
  meta_t             meta_wdata;
  logic              char_we;
  logic [SLOT_W+CIDX_W-1:0] char_addr;

  logic              in_take;
  logic [LEN_W-1:0]  len_nxt;
  logic [SUM_W-1:0]  sum_nxt;
  logic              last_probe;
  logic [SLOT_W-1:0] slot_inc;
  logic [LEN_W-1:0]  cidx_inc;
  logic [CHAR_W-1:0] pend_char;
  logic              out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = !out_valid_r || !out_stall;

  assign len_nxt = (pend_len_r <= LEN_W'(NAME_CHARS)) ? pend_len_r + LEN_W'(1) : pend_len_r;
  assign sum_nxt = sum_r + SUM_W'(in_data.name_char);

  // One multiply a cycle: quotient by reciprocal, back-multiply, scale
  always_comb begin
    mul_a = dvd_r;
    unique case (state_r)
      S_HASH: begin
        mul_b = OPB_W'(HM_RCP);
      end
      S_HREM: begin
        mul_a = quo_r;
        mul_b = OPB_W'(HASH_MODULUS);
      end
      S_SCALE: begin
        mul_b = OPB_W'(SEGMENT_STRIDE);
      end
      S_MODT: begin
        mul_b = OPB_W'(TS_RCP);
      end
      default: begin
        mul_a = quo_r;
        mul_b = OPB_W'(TABLE_SLOTS);
      end
    endcase
  end

  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  assign last_probe = (probe_cnt_r == PC_W'(TABLE_SLOTS - 1));
  assign slot_inc   = (slot_r == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);
  assign cidx_inc   = cidx_r + LEN_W'(1);
  assign pend_char  = pend_chars_r[cidx_r[CIDX_W-1:0]];
  assign char_addr  = {slot_r, cidx_r[CIDX_W-1:0]};

  always_comb begin
    meta_we    = 1'b0;
    meta_wdata = '0;
    if (state_r == S_CLEAR) begin
      meta_we = 1'b1;
    end else if (state_r == S_PROBE_CHK && !meta_q_r.used) begin
      meta_we         = 1'b1;
      meta_wdata.used = 1'b1;
      meta_wdata.len  = pend_len_r;
      meta_wdata.addr = addr_r;
    end
  end

  assign char_we = (state_r == S_WRITE);

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[slot_r] <= meta_wdata;
    end
    meta_q_r <= meta_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[char_addr] <= pend_char;
    end
    char_q_r <= char_mem[char_addr];
  end

  always_ff @(posedge clk) begin
    if (in_take && pend_len_r < LEN_W'(NAME_CHARS)) begin
      pend_chars_r[pend_len_r[CIDX_W-1:0]] <= in_data.name_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      slot_r       <= '0;
      pend_len_r   <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
      probe_cnt_r  <= '0;
      cidx_r       <= '0;
    end else begin
      // A result load in S_RESULT takes over the drained output register
      if (out_valid_r && !out_stall && state_r != S_RESULT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          slot_r <= slot_inc;
          if (slot_r == SLOT_W'(TABLE_SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            pend_len_r <= len_nxt;
            sum_r      <= sum_nxt;
            addr_r     <= in_data.symbol_address;
            if (in_data.name_final) begin
              if (len_nxt > LEN_W'(NAME_CHARS)) begin
                res_status_r <= STATUS_TOO_LONG;
                res_slot_r   <= '0;
                state_r      <= S_RESULT;
              end else begin
                dvd_r   <= DVD_W'(sum_nxt);
                state_r <= S_HASH;
              end
            end
          end
        end
        S_HASH: begin
          quo_r   <= DVD_W'(mul_p >> HM_K);
          state_r <= S_HREM;
        end
        S_HREM: begin
          dvd_r   <= dvd_r - DVD_W'(mul_p);
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          dvd_r   <= DVD_W'(mul_p);
          state_r <= S_MODT;
        end
        S_MODT: begin
          quo_r   <= DVD_W'(mul_p >> TS_K);
          state_r <= S_MREM;
        end
        S_MREM: begin
          slot_r      <= SLOT_W'(dvd_r - DVD_W'(mul_p));
          probe_cnt_r <= '0;
          state_r     <= S_PROBE_RD;
        end
        S_PROBE_RD: begin
          state_r <= S_PROBE_CHK;
        end
        S_PROBE_CHK: begin
          cidx_r <= '0;
          if (!meta_q_r.used) begin
            // Slot record written this cycle; copy the characters next
            res_status_r <= STATUS_INSERTED;
            res_slot_r   <= slot_r;
            state_r      <= S_WRITE;
          end else if (meta_q_r.len == pend_len_r) begin
            state_r <= S_CMP_RD;
          end else if (last_probe) begin
            res_status_r <= STATUS_FULL;
            res_slot_r   <= '0;
            state_r      <= S_RESULT;
          end else begin
            probe_cnt_r <= probe_cnt_r + PC_W'(1);
            slot_r      <= slot_inc;
            state_r     <= S_PROBE_RD;
          end
        end
        S_CMP_RD: begin
          state_r <= S_CMP_CHK;
        end
        S_CMP_CHK: begin
          if (char_q_r != pend_char) begin
            if (last_probe) begin
              res_status_r <= STATUS_FULL;
              res_slot_r   <= '0;
              state_r      <= S_RESULT;
            end else begin
              probe_cnt_r <= probe_cnt_r + PC_W'(1);
              slot_r      <= slot_inc;
              state_r     <= S_PROBE_RD;
            end
          end else if (cidx_inc == pend_len_r) begin
            res_status_r <= STATUS_DUPLICATE;
            res_slot_r   <= slot_r;
            state_r      <= S_RESULT;
          end else begin
            cidx_r  <= cidx_inc;
            state_r <= S_CMP_RD;
          end
        end
        S_WRITE: begin
          cidx_r <= cidx_inc;
          if (cidx_inc == pend_len_r) begin
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          // Hold until the output register is free, then drop the pending name
          if (out_load) begin
            out_valid_r              <= 1'b1;
            out_data_r.insert_status <= res_status_r;
            out_data_r.slot_index    <= INDEX_W'(res_slot_r);
            pend_len_r               <= '0;
            sum_r                    <= '0;
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
